// ----- src/cdad_pkg.sv -----
`timescale 1ns / 1ps

package cdad_pkg;

	localparam int DATE_W      = 27;
	localparam int OFS_W       = 16;
	localparam int DAY_W       = 17;
	localparam int YEAR_W      = 16;
	localparam int YMOD_W      = 9;
	localparam int MON_W       = 4;
	localparam int MDAY_W      = 5;
	localparam int REM_W       = 14;
	localparam int QMON_W      = 7;
	localparam int PROD_W      = 2 * DATE_W;

	localparam int YEAR_DIV    = 10000;
	localparam int MON_DIV     = 100;
	localparam int LEAP_DIV    = 400;
	localparam int CENTURY     = 100;
	localparam int YEAR_MAX    = 9999;
	localparam int MON_MAX     = 12;

	localparam int YEAR_RECIP  = 109951163;
	localparam int YEAR_SHIFT  = 40;
	localparam int MON_RECIP   = 5243;
	localparam int MON_SHIFT   = 19;
	localparam int LEAP_RECIP  = 20972;
	localparam int LEAP_SHIFT  = 23;

	typedef enum logic [1:0] {
		DIV_BY_YEAR,
		DIV_BY_MONTH,
		DIV_BY_LEAP
	} div_sel_t;

	typedef struct packed {
		logic     start;
		div_sel_t sel;
	} div_ctl_t;

	function automatic logic [MDAY_W-1:0] days_in(input logic [MON_W-1:0] m, input logic leap);
		logic [MDAY_W-1:0] len;
		unique case (m)
			MON_W'(2): begin
				len = leap ? MDAY_W'(29) : MDAY_W'(28);
			end
			MON_W'(4), MON_W'(6), MON_W'(9), MON_W'(11): begin
				len = MDAY_W'(30);
			end
			default: begin
				len = MDAY_W'(31);
			end
		endcase
		return len;
	endfunction

	function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
		logic cent;
		cent = (ymod == YMOD_W'(CENTURY)) || (ymod == YMOD_W'(2 * CENTURY))
			|| (ymod == YMOD_W'(3 * CENTURY));
		return (ymod == '0) || ((ymod[1:0] == 2'b00) && !cent);
	endfunction

endpackage

// ----- src/calendar_date_add_days.sv -----
`timescale 1ns / 1ps
// Gregorian date plus a signed day offset, dates packed as decimal YYYYMMDD.
// Request channel: in_valid/in_stall with start_date and day_offset. A request
// is taken when in_valid is high and in_stall is low.
// Result channel: out_valid/out_stall with result_date and out_of_range.
// in_stall stays high from the accepted request until its result is loaded
// into the output register; one request is in work at a time.
// One shared multiplier unpacks the date in three passes (year, month and
// day, year modulo 400) by reciprocal multiplication; then the day is walked
// one month per step, the year and the sum are packed, and the output
// register is loaded. An invalid month goes straight from the month pass to
// the load.
// The next request is taken in the cycle after the result is loaded; the
// largest offsets cross about 1080 months, and the month walk dominates the
// time per request.
// While out_stall holds a result, the finished next result waits in the
// block and in_stall stays high.
// Reset clears the sequencer and the output valid; the block comes up idle.
module calendar_date_add_days (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cdad_pkg::DATE_W-1:0]         start_date,
	input  logic signed [cdad_pkg::OFS_W-1:0]   day_offset,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [cdad_pkg::DATE_W-1:0]         result_date,
	output logic                                out_of_range
);
	import cdad_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		DIV_YEAR,
		DIV_MONTH,
		DIV_LEAP,
		STEP,
		PACK_Y,
		PACK_SUM,
		LOAD_OUT
	} state_t;

	state_t                    state_q;
	logic                      fwd_q;
	logic signed [OFS_W-1:0]   off_q;
	logic signed [YEAR_W-1:0]  y_q;
	logic [YMOD_W-1:0]         ymod_q;
	logic [MON_W-1:0]          m_q;
	logic signed [DAY_W-1:0]   d_q;
	logic [DATE_W-1:0]         prod_q;
	logic [DATE_W-1:0]         pend_date_q;
	logic                      pend_oor_q;
	logic                      out_valid_q;
	logic [DATE_W-1:0]         result_date_q;
	logic                      out_of_range_q;

	div_ctl_t                  div_ctl;
	logic [DATE_W-1:0]         div_dividend;
	logic [REM_W-1:0]          div_quo;
	logic [REM_W-1:0]          div_rem;
	logic                      div_done;

	logic                      leap;
	logic [MDAY_W-1:0]         dim_cur;
	logic [MDAY_W-1:0]         dim_prev;
	logic [MON_W-1:0]          m_prev;
	logic signed [DAY_W-1:0]   dim_cur_s;
	logic signed [DAY_W-1:0]   dim_prev_s;
	logic [QMON_W-1:0]         mon_quo;
	logic                      mon_bad;
	logic                      year_bad;
	logic [DATE_W-1:0]         pack_sum;

	cdad_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dividend),
		.quo      (div_quo),
		.rem      (div_rem),
		.done     (div_done)
	);

	assign leap       = is_leap(ymod_q);
	assign dim_cur    = days_in(m_q, leap);
	assign m_prev     = (m_q == MON_W'(1)) ? MON_W'(MON_MAX) : m_q - MON_W'(1);
	assign dim_prev   = days_in(m_prev, leap);
	assign dim_cur_s  = signed'(DAY_W'(dim_cur));
	assign dim_prev_s = signed'(DAY_W'(dim_prev));
	assign mon_quo    = div_quo[QMON_W-1:0];
	assign mon_bad    = (mon_quo == '0) || (mon_quo > QMON_W'(MON_MAX));
	assign year_bad   = (y_q < YEAR_W'(1)) || (y_q > YEAR_W'(YEAR_MAX));
	assign pack_sum   = prod_q + DATE_W'(m_q) * DATE_W'(MON_DIV) + DATE_W'(d_q[QMON_W-1:0]);

	always_comb begin
		div_ctl      = '0;
		div_dividend = start_date;
		unique case (state_q)
			IDLE: begin
				div_ctl.start = in_valid;
				div_ctl.sel   = DIV_BY_YEAR;
			end
			DIV_YEAR: begin
				div_ctl.start = div_done;
				div_ctl.sel   = DIV_BY_MONTH;
				div_dividend  = DATE_W'(div_rem);
			end
			DIV_MONTH: begin
				div_ctl.start = div_done && !mon_bad;
				div_ctl.sel   = DIV_BY_LEAP;
				div_dividend  = DATE_W'(y_q[REM_W-1:0]);
			end
			default: begin
				div_ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == LOAD_OUT) begin
				if (!out_valid_q || !out_stall) begin
					out_valid_q <= 1'b1;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= DIV_YEAR;
					end
				end
				DIV_YEAR: begin
					if (div_done) begin
						state_q <= DIV_MONTH;
					end
				end
				DIV_MONTH: begin
					if (div_done) begin
						state_q <= mon_bad ? LOAD_OUT : DIV_LEAP;
					end
				end
				DIV_LEAP: begin
					if (div_done) begin
						state_q <= STEP;
					end
				end
				STEP: begin
					if (fwd_q ? !(d_q > dim_cur_s) : !(d_q < DAY_W'(1))) begin
						state_q <= PACK_Y;
					end
				end
				PACK_Y: begin
					state_q <= year_bad ? LOAD_OUT : PACK_SUM;
				end
				PACK_SUM: begin
					state_q <= LOAD_OUT;
				end
				LOAD_OUT: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			IDLE: begin
				if (in_valid) begin
					off_q <= day_offset;
					fwd_q <= !day_offset[OFS_W-1];
				end
			end
			DIV_YEAR: begin
				if (div_done) begin
					y_q <= signed'(YEAR_W'(div_quo));
				end
			end
			DIV_MONTH: begin
				if (div_done) begin
					m_q         <= mon_quo[MON_W-1:0];
					d_q         <= signed'(DAY_W'(div_rem[QMON_W-1:0])) + DAY_W'(off_q);
					pend_date_q <= '0;
					pend_oor_q  <= 1'b1;
				end
			end
			DIV_LEAP: begin
				if (div_done) begin
					ymod_q <= div_rem[YMOD_W-1:0];
				end
			end
			STEP: begin
				if (fwd_q && (d_q > dim_cur_s)) begin
					d_q <= d_q - dim_cur_s;
					if (m_q == MON_W'(MON_MAX)) begin
						m_q    <= MON_W'(1);
						y_q    <= y_q + YEAR_W'(1);
						ymod_q <= (ymod_q == YMOD_W'(LEAP_DIV - 1)) ? '0 : ymod_q + YMOD_W'(1);
					end else begin
						m_q <= m_q + MON_W'(1);
					end
				end else if (!fwd_q && (d_q < DAY_W'(1))) begin
					d_q <= d_q + dim_prev_s;
					m_q <= m_prev;
					if (m_q == MON_W'(1)) begin
						y_q    <= y_q - YEAR_W'(1);
						ymod_q <= (ymod_q == '0) ? YMOD_W'(LEAP_DIV - 1) : ymod_q - YMOD_W'(1);
					end
				end
			end
			PACK_Y: begin
				prod_q      <= DATE_W'(y_q[REM_W-1:0]) * DATE_W'(YEAR_DIV);
				pend_date_q <= '0;
				pend_oor_q  <= year_bad;
			end
			PACK_SUM: begin
				pend_date_q <= pack_sum;
			end
			LOAD_OUT: begin
				if (!out_valid_q || !out_stall) begin
					result_date_q  <= pend_date_q;
					out_of_range_q <= pend_oor_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall     = (state_q != IDLE);
	assign out_valid    = out_valid_q;
	assign result_date  = result_date_q;
	assign out_of_range = out_of_range_q;

endmodule

// ----- src/cdad_div.sv -----
`timescale 1ns / 1ps

module cdad_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cdad_pkg::div_ctl_t            ctl,
	input  logic [cdad_pkg::DATE_W-1:0]   dividend,
	output logic [cdad_pkg::REM_W-1:0]    quo,
	output logic [cdad_pkg::REM_W-1:0]    rem,
	output logic                          done
);
	import cdad_pkg::*;

	logic [DATE_W-1:0] num_q;
	div_sel_t          sel_q;
	logic [REM_W-1:0]  quo_q;
	logic [REM_W-1:0]  rem_q;
	logic              quo_pass_q;
	logic              rem_pass_q;
	logic              done_q;
	logic [DATE_W-1:0] recip;
	logic [DATE_W-1:0] divisor;
	logic [DATE_W-1:0] mul_a;
	logic [DATE_W-1:0] mul_b;
	logic [PROD_W-1:0] prod;
	logic [REM_W-1:0]  quo_next;
	logic [DATE_W-1:0] diff;

	assign mul_a = rem_pass_q ? DATE_W'(quo_q) : num_q;
	assign mul_b = rem_pass_q ? divisor : recip;
	assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign diff  = num_q - prod[DATE_W-1:0];

	always_comb begin
		unique case (sel_q)
			DIV_BY_MONTH: begin
				recip    = DATE_W'(MON_RECIP);
				divisor  = DATE_W'(MON_DIV);
				quo_next = prod[MON_SHIFT +: REM_W];
			end
			DIV_BY_LEAP: begin
				recip    = DATE_W'(LEAP_RECIP);
				divisor  = DATE_W'(LEAP_DIV);
				quo_next = prod[LEAP_SHIFT +: REM_W];
			end
			default: begin
				recip    = DATE_W'(YEAR_RECIP);
				divisor  = DATE_W'(YEAR_DIV);
				quo_next = prod[YEAR_SHIFT +: REM_W];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_pass_q <= 1'b0;
			rem_pass_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			quo_pass_q <= ctl.start;
			rem_pass_q <= quo_pass_q;
			done_q     <= rem_pass_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= dividend;
			sel_q <= ctl.sel;
		end
		if (quo_pass_q) begin
			quo_q <= quo_next;
		end
		if (rem_pass_q) begin
			rem_q <= diff[REM_W-1:0];
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

// ----- src/cdad_chk.sv -----
`timescale 1ns / 1ps

module cdad_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic [cdad_pkg::DATE_W-1:0]         start_date,
	input logic signed [cdad_pkg::OFS_W-1:0]   day_offset,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [cdad_pkg::DATE_W-1:0]         result_date,
	input logic                                out_of_range
);
	import cdad_pkg::*;

	// hold off new requests while one is in work
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one in work");

	// drop the date on a range fault
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> result_date == '0)
		else $error("out_of_range result with nonzero date");

	a_date_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_of_range |->
			result_date >= DATE_W'(10100) && result_date <= DATE_W'(99991299))
		else $error("result date outside packed range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_date)
			&& $stable(out_of_range))
		else $error("stalled result changed");

	// no new result may appear while the request side is still open
	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && !out_valid |=> !out_valid)
		else $error("result without request");

endmodule

bind calendar_date_add_days cdad_chk u_cdad_chk (.*);

// ----- dv/tb_calendar_date_add_days.sv -----
`timescale 1ns / 1ps

module tb_calendar_date_add_days;

	import cdad_pkg::*;

	typedef struct packed {
		logic [DATE_W-1:0] date;
		logic              oor;
	} date_result_t;

	typedef struct packed {
		logic [DATE_W-1:0] start;
		logic [OFS_W-1:0]  ofs;
		logic              typed;
		logic [DATE_W-1:0] want_date;
		logic              want_oor;
	} date_case_t;

	localparam int N_CASES    = 22;
	localparam int N_RANDOM   = 450;
	localparam int DRAIN_WAIT = 1200;
	localparam int CALM_FIRST = 200;
	localparam int CALM_LAST  = 299;
	localparam int PAUSE_AT   = 350;
	localparam int DATE_MAX   = 99991231;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [DATE_W-1:0]       start_date = '0;
	logic signed [OFS_W-1:0] day_offset = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [DATE_W-1:0]       result_date;
	logic                    out_of_range;

	date_result_t pending_dates[$];
	date_case_t   cases [N_CASES];
	bit           calm = 1'b0;
	int           n_errors = 0;
	int           n_requests = 0;
	int           n_results = 0;
	int           n_flagged = 0;

	calendar_date_add_days u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.start_date   (start_date),
		.day_offset   (day_offset),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_date  (result_date),
		.out_of_range (out_of_range)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#25_000_000;
		$display("calendar_date_add_days: mismatch");
		$finish;
	end

	function automatic bit leap_year(input int y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int month_days(input int m, input int y);
		int len;
		case (m)
			2: begin
				len = leap_year(y) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				len = 30;
			end
			default: begin
				len = 31;
			end
		endcase
		return len;
	endfunction

	function automatic date_result_t shift_date(input logic [DATE_W-1:0] sd,
			input logic signed [OFS_W-1:0] ofs);
		date_result_t r;
		int y;
		int m;
		int d;
		int o;
		y = int'(sd) / YEAR_DIV;
		m = (int'(sd) / MON_DIV) % MON_DIV;
		d = int'(sd) % MON_DIV;
		o = ofs;
		r = '0;
		if (m < 1 || m > MON_MAX) begin
			r.oor = 1'b1;
			return r;
		end
		d += o;
		if (o >= 0) begin
			while (d > month_days(m, y)) begin
				d -= month_days(m, y);
				m++;
				if (m > MON_MAX) begin
					m = 1;
					y++;
				end
			end
		end else begin
			while (d < 1) begin
				m--;
				if (m < 1) begin
					m = MON_MAX;
					y--;
				end
				d += month_days(m, y);
			end
		end
		if (y < 1 || y > YEAR_MAX) begin
			r.oor = 1'b1;
		end else begin
			r.date = DATE_W'(y * YEAR_DIV + m * MON_DIV + d);
		end
		return r;
	endfunction

	function automatic logic [DATE_W-1:0] random_date();
		int r;
		int y;
		int m;
		int d;
		int v;
		r = $urandom_range(99);
		if (r < 5)
			return DATE_W'($urandom_range(DATE_MAX));
		if (r < 20)
			y = $urandom_range(1) ? $urandom_range(3) : YEAR_MAX - $urandom_range(3);
		else
			y = $urandom_range(YEAR_MAX);
		m = ($urandom_range(99) < 90) ? $urandom_range(MON_MAX, 1) : $urandom_range(99);
		d = ($urandom_range(99) < 85) ? $urandom_range(31, 1) : $urandom_range(99);
		v = y * YEAR_DIV + m * MON_DIV + d;
		if (v > DATE_MAX)
			v = DATE_MAX;
		return DATE_W'(v);
	endfunction

	function automatic logic signed [OFS_W-1:0] random_offset();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 60)
			return OFS_W'($urandom_range(800) - 400);
		if (r < 85)
			return OFS_W'($urandom_range(12000) - 6000);
		return OFS_W'($urandom_range(65535));
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		n_errors++;
		$display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
	endtask

	task automatic push_request(input logic [DATE_W-1:0] sd, input logic signed [OFS_W-1:0] ofs,
			input bit typed, input date_result_t want);
		while (!calm && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		start_date <= sd;
		day_offset <= ofs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_dates.push_back(typed ? want : shift_date(sd, ofs));
		n_requests++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (calm)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < 29);
	end

	always @(posedge clk) begin
		date_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (out_of_range)
				n_flagged++;
			if (pending_dates.size() == 0) begin
				flag_mismatch("result with no request", result_date, 0);
			end else begin
				want = pending_dates.pop_front();
				if (result_date !== want.date)
					flag_mismatch("result_date", result_date, want.date);
				if (out_of_range !== want.oor)
					flag_mismatch("out_of_range", out_of_range, want.oor);
			end
		end
	end

	initial begin
		date_result_t want;
		cases = '{
			'{27'd20240101, 16'sd0,      1'b1, 27'd20240101, 1'b0},
			'{27'd99991231, 16'sd0,      1'b1, 27'd99991231, 1'b0},
			'{27'd00010101, 16'sd0,      1'b1, 27'd00010101, 1'b0},
			'{27'd20240100, 16'sd0,      1'b1, 27'd20240100, 1'b0},
			'{27'd00000000, 16'sd0,      1'b1, 27'd0,        1'b1},
			'{27'd20241301, 16'sd5,      1'b1, 27'd0,        1'b1},
			'{27'd20249931, -16'sd3,     1'b1, 27'd0,        1'b1},
			'{27'd20240031, 16'sd32767,  1'b1, 27'd0,        1'b1},
			'{27'd99991231, 16'sd1,      1'b1, 27'd0,        1'b1},
			'{27'd00010101, -16'sd1,     1'b1, 27'd0,        1'b1},
			'{27'd00000101, -16'sd1,     1'b1, 27'd0,        1'b1},
			'{27'd99990101, 16'sd32767,  1'b1, 27'd0,        1'b1},
			'{27'd00010101, -16'sd32768, 1'b1, 27'd0,        1'b1},
			'{27'd00001231, 16'sd1,      1'b0, 27'd0,        1'b0},
			'{27'd20240299, 16'sd0,      1'b0, 27'd0,        1'b0},
			'{27'd20240228, 16'sd1,      1'b0, 27'd0,        1'b0},
			'{27'd19000228, 16'sd1,      1'b0, 27'd0,        1'b0},
			'{27'd20000228, 16'sd1,      1'b0, 27'd0,        1'b0},
			'{27'd20241231, 16'sd1,      1'b0, 27'd0,        1'b0},
			'{27'd20240301, -16'sd1,     1'b0, 27'd0,        1'b0},
			'{27'd50000615, 16'sd32767,  1'b0, 27'd0,        1'b0},
			'{27'd50000615, -16'sd32768, 1'b0, 27'd0,        1'b0}
		};
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (cases[i]) begin
			want.date = cases[i].want_date;
			want.oor  = cases[i].want_oor;
			push_request(cases[i].start, cases[i].ofs, cases[i].typed, want);
		end
		drain_results();
		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= CALM_FIRST && i <= CALM_LAST);
			if (i == PAUSE_AT)
				drain_results();
			push_request(random_date(), random_offset(), 1'b0, '0);
		end
		calm = 1'b0;
		drain_results();
		repeat (DRAIN_WAIT)
			@(posedge clk);
		$display("covered %0d requests (%0d directed), %0d results, %0d flagged out of range",
			n_requests, N_CASES, n_results, n_flagged);
		$display("leap years, month and year wrap, bad months and year overflow both ways");
		if (n_errors == 0)
			$display("calendar_date_add_days: match");
		else
			$display("calendar_date_add_days: mismatch");
		$finish;
	end

endmodule
